[hdl/sfp_pkg.sv]
package sfp_pkg;

    // default frame store depth in bytes
    localparam int FRAME_BYTES_DEF = 40;

    // header cells that the decoder looks at (tags and digit positions)
    localparam int HDR_FIRST = 1;
    localparam int HDR_LAST  = 14;

    // working width of the digit sums, wide enough for any byte pattern
    localparam int SUM_W   = 36;
    localparam int VALUE_W = 33;
    localparam int KIND_W  = 4;
    localparam int LIMIT_W = 16;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_CO2_JUMP_LIMIT = 1'b0;   // word select bit of paddr
    localparam logic [LIMIT_W-1:0] CO2_LIMIT_RST = 16'd3000;
    localparam logic [LIMIT_W-1:0] CO2_LAST_RST  = 16'd800;

    // ascii codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;   // '$'
    localparam logic [7:0] CH_STAR   = 8'h2A;   // '*'
    localparam logic [7:0] CH_ZERO   = 8'h30;   // '0'
    localparam logic [7:0] CH_ONE    = 8'h31;   // '1'
    localparam logic [7:0] CH_TWO    = 8'h32;   // '2'
    localparam logic [7:0] CH_UP_C   = 8'h43;   // 'C'
    localparam logic [7:0] CH_G      = 8'h67;   // 'g'
    localparam logic [7:0] CH_H      = 8'h68;   // 'h'
    localparam logic [7:0] CH_R      = 8'h72;   // 'r'
    localparam logic [7:0] CH_T      = 8'h74;   // 't'

    typedef enum logic [KIND_W-1:0] {
        KIND_TEMP1      = 4'd0,
        KIND_PRESSURE   = 4'd1,
        KIND_HUMIDITY1  = 4'd2,
        KIND_GAS_RES    = 4'd3,
        KIND_HUMIDITY2  = 4'd4,
        KIND_TEMP2      = 4'd5,
        KIND_CO2        = 4'd6,
        KIND_GAS1       = 4'd7,
        KIND_UNKNOWN    = 4'd8,
        KIND_CO2_REJECT = 4'd9
    } t_kind;

    typedef enum logic {
        ST_IDLE    = 1'b0,
        ST_COLLECT = 1'b1
    } t_coll_state;

    // frame closed this cycle, with the header cells as they stand after the closing byte
    typedef struct packed {
        logic                            fire;
        logic [HDR_LAST:HDR_FIRST][7:0]  hdr;
    } t_frame;

    // ascii digit to signed value, no range check
    function automatic logic signed [SUM_W-1:0] digit(input logic [7:0] b);
        digit = $signed({{(SUM_W-8){1'b0}}, b}) - $signed({{(SUM_W-8){1'b0}}, CH_ZERO});
    endfunction

endpackage

[hdl/sfp_cfg.sv]
module sfp_cfg
    import sfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [LIMIT_W-1:0]    o_co2_limit
);

    logic [LIMIT_W-1:0] r_limit;
    logic               wr_en;
    logic               sel_limit;

    assign sel_limit = (paddr[CFG_ADDR_W-1] == REG_CO2_JUMP_LIMIT);
    assign wr_en     = psel & penable & pwrite & sel_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= CO2_LIMIT_RST;
        end else if (wr_en) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata      = sel_limit ? {{(CFG_DATA_W-LIMIT_W){1'b0}}, r_limit} : '0;
    assign pready      = 1'b1;
    assign o_co2_limit = r_limit;

endmodule

[hdl/sfp_collect.sv]
module sfp_collect
    import sfp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data,
    output logic       o_ready,
    input  logic       i_slot_free,
    output t_frame     o_frame
);

    localparam int IDX_W = $clog2(FRAME_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(FRAME_BYTES);

    logic                           r_in_valid;
    logic [7:0]                     r_in_byte;
    t_coll_state                    r_state;
    t_coll_state                    n_state;
    logic [IDX_W-1:0]               r_idx;
    logic [IDX_W-1:0]               n_idx;
    logic [HDR_LAST:HDR_FIRST][7:0] r_cell;
    logic [HDR_LAST:HDR_FIRST][7:0] n_cell;

    logic go;
    logic is_dollar;
    logic is_star;
    logic active;
    logic has_room;
    logic store_en;

    assign go        = r_in_valid & i_slot_free;
    assign o_ready   = ~r_in_valid | i_slot_free;
    assign is_dollar = (r_in_byte == CH_DOLLAR);
    assign is_star   = (r_in_byte == CH_STAR);
    assign active    = (r_state == ST_COLLECT) | is_dollar;
    assign has_room  = (r_idx < IDX_FULL);
    assign store_en  = go & active & has_room;

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_byte <= i_data;
        end
    end

    always_comb begin
        n_state = r_state;
        if (go) begin
            unique case (r_state)
                ST_IDLE: begin
                    if (is_dollar) n_state = ST_COLLECT;
                end
                ST_COLLECT: begin
                    if (is_star) n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        n_idx  = r_idx;
        n_cell = r_cell;
        if (go) begin
            if (!active) begin
                n_idx = '0;
            end else if (is_star) begin
                n_idx = '0;
            end else if (has_room) begin
                n_idx = r_idx + 1'b1;
            end
        end
        for (int k = HDR_FIRST; k <= HDR_LAST; k++) begin
            if (store_en && (r_idx == IDX_W'(k))) begin
                n_cell[k] = r_in_byte;
            end
        end
        o_frame.fire = go & active & is_star;
        o_frame.hdr  = n_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_cell  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cell  <= n_cell;
        end
    end

endmodule

[hdl/sfp_decode.sv]
module sfp_decode
    import sfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_frame               i_frame,
    input  logic [LIMIT_W-1:0]   i_co2_limit,
    input  logic                 i_out_ready,
    output logic                 o_slot_free,
    output logic                 o_valid,
    output logic [KIND_W-1:0]    o_kind,
    output logic [VALUE_W-1:0]   o_value
);

    logic                      r_valid;
    t_kind                     r_kind;
    logic [VALUE_W-1:0]        r_value;
    logic [LIMIT_W-1:0]        r_last_co2;

    t_kind                     n_kind;
    logic [VALUE_W-1:0]        n_value;
    logic                      co2_keep;

    logic [7:0]                b1;
    logic [7:0]                b2;
    logic [7:0]                b5;
    logic signed [SUM_W-1:0]   d6, d7, d8, d9, d10, d11, d13, d14;
    logic signed [SUM_W-1:0]   s_five;
    logic signed [SUM_W-1:0]   s_eight;
    logic signed [SUM_W-1:0]   s_three;
    logic signed [SUM_W-1:0]   s_six;
    logic signed [SUM_W-1:0]   s_six_h;
    logic [LIMIT_W-1:0]        co2_read;
    logic [VALUE_W-1:0]        co2_value;
    logic signed [LIMIT_W+1:0] co2_diff;
    logic signed [LIMIT_W+1:0] co2_lim;

    assign b1  = i_frame.hdr[1];
    assign b2  = i_frame.hdr[2];
    assign b5  = i_frame.hdr[5];
    assign d6  = digit(i_frame.hdr[6]);
    assign d7  = digit(i_frame.hdr[7]);
    assign d8  = digit(i_frame.hdr[8]);
    assign d9  = digit(i_frame.hdr[9]);
    assign d10 = digit(i_frame.hdr[10]);
    assign d11 = digit(i_frame.hdr[11]);
    assign d13 = digit(i_frame.hdr[13]);
    assign d14 = digit(i_frame.hdr[14]);

    // constant-weight digit sums
    assign s_five  = d6 * 36'sd10000 + d7 * 36'sd1000 + d8 * 36'sd100
                   + d10 * 36'sd10 + d11;
    assign s_eight = d6 * 36'sd10000000 + d7 * 36'sd1000000 + d8 * 36'sd100000
                   + d9 * 36'sd10000 + d10 * 36'sd1000 + d11 * 36'sd100
                   + d13 * 36'sd10 + d14;
    assign s_three = d6 * 36'sd10000 + d7 * 36'sd1000 + d8 * 36'sd100;
    assign s_six   = d6 * 36'sd100000 + d7 * 36'sd10000 + d8 * 36'sd1000
                   + d9 * 36'sd100 + d10 * 36'sd10 + d11;
    assign s_six_h = d6 * 36'sd10000000 + d7 * 36'sd1000000 + d8 * 36'sd100000
                   + d9 * 36'sd10000 + d10 * 36'sd1000 + d11 * 36'sd100;

    // co2 reading wraps to 16 bits, kept only within the jump limit
    assign co2_read  = s_six[LIMIT_W-1:0];
    assign co2_value = VALUE_W'(co2_read) * VALUE_W'(100);
    assign co2_diff  = $signed({2'b00, co2_read}) - $signed({2'b00, r_last_co2});
    assign co2_lim   = $signed({2'b00, i_co2_limit});
    assign co2_keep  = (co2_diff < co2_lim) && (co2_diff > -co2_lim);

    always_comb begin
        priority if (b1 == CH_T && b5 == CH_ONE) begin
            n_kind  = KIND_TEMP1;
            n_value = s_five[VALUE_W-1:0];
        end else if (b2 == CH_R && b5 == CH_ONE) begin
            n_kind  = KIND_PRESSURE;
            n_value = s_eight[VALUE_W-1:0];
        end else if (b1 == CH_H && b5 == CH_ONE) begin
            n_kind  = KIND_HUMIDITY1;
            n_value = s_five[VALUE_W-1:0];
        end else if (b1 == CH_G) begin
            n_kind  = KIND_GAS_RES;
            n_value = s_eight[VALUE_W-1:0];
        end else if (b1 == CH_H && b5 == CH_TWO) begin
            n_kind  = KIND_HUMIDITY2;
            n_value = s_three[VALUE_W-1:0];
        end else if (b1 == CH_T && b5 == CH_TWO) begin
            n_kind  = KIND_TEMP2;
            n_value = s_three[VALUE_W-1:0];
        end else if (b1 == CH_UP_C) begin
            n_kind  = co2_keep ? KIND_CO2 : KIND_CO2_REJECT;
            n_value = co2_value;
        end else if (b2 == CH_G && b5 == CH_ONE) begin
            n_kind  = KIND_GAS1;
            n_value = s_six_h[VALUE_W-1:0];
        end else begin
            n_kind  = KIND_UNKNOWN;
            n_value = '0;
        end
    end

    assign o_slot_free = ~r_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_last_co2 <= CO2_LAST_RST;
        end else begin
            if (i_frame.fire) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
            if (i_frame.fire && n_kind == KIND_CO2) begin
                r_last_co2 <= co2_read;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.fire) begin
            r_kind  <= n_kind;
            r_value <= n_value;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_value = r_value;

endmodule

[hdl/sensor_frame_parser.sv]
// a closing '*' beat goes through the input register and then the result register
// throughput: one byte beat per cycle unless a record waits at the output, set by the
// input register feeding the frame logic; a waiting record holds the beat there, stalling input
// reset (i_rst_n low at a clock edge) clears the collector, the header cells to zeros,
// last kept co2 to 800 and the co2 jump limit to 3000
module sensor_frame_parser
    import sfp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // byte stream in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
    // record stream out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,   // [32:0] value_hundredths, [39:33] zero
    output logic [KIND_W-1:0]     m_axis_tuser,   // [3:0] record_kind
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_frame               frame;
    logic                 slot_free;
    logic [LIMIT_W-1:0]   co2_limit;
    logic [VALUE_W-1:0]   value;

    // co2 jump limit register, word 0
    sfp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_co2_limit (co2_limit)
    );

    // input register plus '$'..'*' collector; only cells 1..14, holding all the
    // decoder reads, are stored, the rest of the frame is counted but discarded
    sfp_collect #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_collect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_data      (s_axis_tdata),
        .o_ready     (s_axis_tready),
        .i_slot_free (slot_free),
        .o_frame     (frame)
    );

    // tag match, digit sums and co2 filter into the result register
    sfp_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (frame),
        .i_co2_limit (co2_limit),
        .i_out_ready (m_axis_tready),
        .o_slot_free (slot_free),
        .o_valid     (m_axis_tvalid),
        .o_kind      (m_axis_tuser),
        .o_value     (value)
    );

    // pad the value up to whole bytes
    assign m_axis_tdata = {{(40-VALUE_W){1'b0}}, value};

endmodule

[hdl/sfp_checker.sv]
module sfp_checker
    import sfp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [39:0]       m_axis_tdata,
    input logic [KIND_W-1:0] m_axis_tuser
);

    // a stalled record stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("record dropped while stalled");

    // a stalled record keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("record changed while stalled");

    // unknown tag carries a zero value
    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_UNKNOWN |-> m_axis_tdata == 40'd0)
        else $error("unknown tag with nonzero value");

    // co2 values come from a 16-bit reading times 100
    a_co2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_CO2 || m_axis_tuser == KIND_CO2_REJECT)
        |-> m_axis_tdata <= 40'd6553500)
        else $error("co2 value out of range");

endmodule

bind sensor_frame_parser sfp_checker u_sfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[sim/tb_sensor_frame_parser.sv]
`timescale 1ns / 100ps

module tb_sensor_frame_parser;
    import sfp_pkg::*;

    // store depth of the shadow copy; the block indexes it with six bits
    localparam int STORE_CELLS = 64;
    localparam int FRAME_BYTES = FRAME_BYTES_DEF;

    // a closing beat shows its record after the input and result registers; this settles all
    localparam int SETTLE_CYCLES = 8;
    // nothing accepted for this long means the block is stuck
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int IDLE_PCT = 22;

    localparam logic [CFG_ADDR_W-1:0] ADDR_CO2_JUMP_LIMIT = '0;

    // how the digit positions of a generated frame are filled
    typedef enum int {
        FILL_ASCII,
        FILL_ANY,
        FILL_ZERO_BYTES,
        FILL_ONE_BYTES
    } t_digit_fill;

    typedef struct {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
    } t_sensor_record;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;     // [7:0] rx_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;          // [32:0] value_hundredths, [39:33] zero
    logic [KIND_W-1:0]     m_axis_tuser;          // [3:0] record_kind
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    sensor_frame_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // shadow of the parser state, advanced once per accepted byte beat
    logic [7:0]  shadow_cells [STORE_CELLS];
    logic        shadow_collecting;
    logic [5:0]  shadow_index;
    logic [15:0] shadow_last_co2;
    logic [15:0] shadow_limit;

    t_sensor_record expected_records [$];
    logic [7:0]     pending_bytes [$];

    int   error_count = 0;
    int   bytes_accepted = 0;
    int   bytes_queued = 0;
    int   stall_cycles = 0;
    int   hold_left = 0;
    int   hold_at_byte = -1;
    logic hold_done = 1'b0;
    logic quiet_phase = 1'b0;

    // frame under construction by the stimulus tasks
    logic [7:0] draft_frame [STORE_CELLS];
    int         draft_len;
    int         gen_limit = 3000;
    int         gen_co2 = 800;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // ascii digit without range check, any byte gives a signed value
    function automatic longint cell_digit(input int pos);
        return longint'(shadow_cells[pos]) - 48;
    endfunction

    task automatic decode_frame(output t_sensor_record rec);
        logic [7:0]  tag1;
        logic [7:0]  tag2;
        logic [7:0]  tag5;
        longint      six;
        longint      five;
        longint      three;
        longint      eight;
        longint      sum;
        logic [15:0] reading;
        int          diff;
        tag1 = shadow_cells[1];
        tag2 = shadow_cells[2];
        tag5 = shadow_cells[5];
        six = cell_digit(6) * 100000 + cell_digit(7) * 10000 + cell_digit(8) * 1000
            + cell_digit(9) * 100 + cell_digit(10) * 10 + cell_digit(11);
        five = cell_digit(6) * 10000 + cell_digit(7) * 1000 + cell_digit(8) * 100
             + cell_digit(10) * 10 + cell_digit(11);
        three = (cell_digit(6) * 100 + cell_digit(7) * 10 + cell_digit(8)) * 100;
        eight = six * 100 + cell_digit(13) * 10 + cell_digit(14);
        // tag tests in priority order, first hit wins
        if (tag1 == CH_T && tag5 == CH_ONE) begin
            rec.kind = KIND_TEMP1;
            sum = five;
        end else if (tag2 == CH_R && tag5 == CH_ONE) begin
            rec.kind = KIND_PRESSURE;
            sum = eight;
        end else if (tag1 == CH_H && tag5 == CH_ONE) begin
            rec.kind = KIND_HUMIDITY1;
            sum = five;
        end else if (tag1 == CH_G) begin
            rec.kind = KIND_GAS_RES;
            sum = eight;
        end else if (tag1 == CH_H && tag5 == CH_TWO) begin
            rec.kind = KIND_HUMIDITY2;
            sum = three;
        end else if (tag1 == CH_T && tag5 == CH_TWO) begin
            rec.kind = KIND_TEMP2;
            sum = three;
        end else if (tag1 == CH_UP_C) begin
            // reading wraps to 16 bits; the window is open at both ends
            reading = six[15:0];
            sum = longint'(reading) * 100;
            diff = int'(reading) - int'(shadow_last_co2);
            if (diff < int'(shadow_limit) && diff > -int'(shadow_limit)) begin
                shadow_last_co2 = reading;
                rec.kind = KIND_CO2;
            end else begin
                rec.kind = KIND_CO2_REJECT;
            end
        end else if (tag2 == CH_G && tag5 == CH_ONE) begin
            rec.kind = KIND_GAS1;
            sum = six * 100;
        end else begin
            rec.kind = KIND_UNKNOWN;
            sum = 0;
        end
        rec.value = sum[VALUE_W-1:0];
    endtask

    task automatic predict_record(input logic [7:0] rx);
        t_sensor_record rec;
        if (rx == CH_DOLLAR)
            shadow_collecting = 1'b1;
        // outside a frame every byte is dropped and the index cleared
        if (!shadow_collecting) begin
            shadow_index = '0;
            return;
        end
        // a full store drops the byte, a closing star still decodes
        if (shadow_index < FRAME_BYTES) begin
            shadow_cells[shadow_index] = rx;
            shadow_index = shadow_index + 1'b1;
        end
        if (rx == CH_STAR) begin
            shadow_collecting = 1'b0;
            shadow_index = '0;
            decode_frame(rec);
            expected_records.push_back(rec);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    // any byte except the closing star
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == CH_STAR)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    // len counts the bytes before the closing star, the leading dollar included
    task automatic build_frame(input t_kind kind, input t_digit_fill fill, input int len);
        int i;
        draft_frame[0] = CH_DOLLAR;
        for (i = 1; i < STORE_CELLS; i++)
            draft_frame[i] = body_byte();
        for (i = 6; i <= 14; i++) begin
            case (fill)
                FILL_ASCII:      draft_frame[i] = CH_ZERO + 8'($urandom_range(9));
                FILL_ZERO_BYTES: draft_frame[i] = 8'h00;
                FILL_ONE_BYTES:  draft_frame[i] = 8'hFF;
                default: ;
            endcase
        end
        case (kind)
            KIND_TEMP1: begin
                draft_frame[1] = CH_T;
                draft_frame[5] = CH_ONE;
            end
            KIND_PRESSURE: begin
                draft_frame[2] = CH_R;
                draft_frame[5] = CH_ONE;
            end
            KIND_HUMIDITY1: begin
                draft_frame[1] = CH_H;
                draft_frame[5] = CH_ONE;
            end
            KIND_GAS_RES: draft_frame[1] = CH_G;
            KIND_HUMIDITY2: begin
                draft_frame[1] = CH_H;
                draft_frame[5] = CH_TWO;
            end
            KIND_TEMP2: begin
                draft_frame[1] = CH_T;
                draft_frame[5] = CH_TWO;
            end
            KIND_CO2:  draft_frame[1] = CH_UP_C;
            KIND_GAS1: begin
                draft_frame[2] = CH_G;
                draft_frame[5] = CH_ONE;
            end
            default: ;   // random tag bytes, almost always unknown
        endcase
        draft_len = len;
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < draft_len; i++)
            push_byte(draft_frame[i]);
        push_byte(CH_STAR);
    endtask

    // six ascii digits at positions 6..11
    task automatic set_reading(input int r);
        int i;
        for (i = 0; i < 6; i++) begin
            draft_frame[11 - i] = CH_ZERO + 8'(r % 10);
            r = r / 10;
        end
    endtask

    // co2 reading around the last one we expect to be kept, often right on the window edge
    task automatic next_co2_reading();
        int pick;
        int r;
        int d;
        pick = $urandom_range(9);
        if (pick < 6)
            r = gen_co2 + int'($urandom_range(2 * gen_limit + 10)) - gen_limit - 5;
        else if (pick < 8)
            r = gen_co2 + ($urandom_range(1) ? gen_limit : -gen_limit)
              + int'($urandom_range(2)) - 1;
        else
            r = $urandom_range(999999);
        if (r < 0)
            r = -r;
        r = r % 1000000;
        d = (r % 65536) - gen_co2;
        if (d < gen_limit && d > -gen_limit)
            gen_co2 = r % 65536;
        set_reading(r);
    endtask

    // mostly well formed frames with random content, some noise and unfinished frames
    task automatic queue_random(input int count);
        int    goal;
        int    pick;
        int    len;
        t_kind kind;
        t_digit_fill fill;
        goal = bytes_queued + count;
        while (bytes_queued < goal) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                // line noise, may hold a dollar or a star
                repeat ($urandom_range(8, 1))
                    push_byte(8'($urandom_range(255)));
            end else if (pick < 17) begin
                // frame cut short, the next dollar lands inside it
                push_byte(CH_DOLLAR);
                repeat ($urandom_range(10, 1))
                    push_byte(body_byte());
            end else begin
                pick = $urandom_range(99);
                if (pick < 70)
                    len = $urandom_range(20, 15);
                else if (pick < 80)
                    len = $urandom_range(14, 1);
                else if (pick < 90)
                    len = $urandom_range(48, 38);
                else
                    len = $urandom_range(37, 21);
                pick = $urandom_range(99);
                if (pick < 60)
                    fill = FILL_ASCII;
                else if (pick < 90)
                    fill = FILL_ANY;
                else if (pick < 95)
                    fill = FILL_ZERO_BYTES;
                else
                    fill = FILL_ONE_BYTES;
                kind = t_kind'($urandom_range(KIND_UNKNOWN));
                build_frame(kind, fill, len);
                if (kind == KIND_CO2 && $urandom_range(9) < 8)
                    next_co2_reading();
                send_frame();
            end
        end
    endtask

    // sender drained, every record back, then a short settle
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_records.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup cycle then access cycle, written at the access edge
    task automatic write_jump_limit(input logic [LIMIT_W-1:0] limit);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CO2_JUMP_LIMIT;
        pwdata  <= {{(CFG_DATA_W - LIMIT_W){1'b0}}, limit};
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_limit = limit;
        gen_limit = limit;
    endtask

    // ------------------------------------------------------------------
    // byte beat driver
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_record(s_axis_tdata);
                bytes_accepted <= bytes_accepted + 1;
            end
            // a beat on offer stays until taken
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_bytes.size() != 0 &&
                    (quiet_phase || $urandom_range(99) >= IDLE_PCT)) begin
                    s_axis_tdata  <= pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // record receiver: random stalls and one long hold-off
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!hold_done && hold_at_byte >= 0 && bytes_accepted >= hold_at_byte) begin
            // sender keeps going, so the output fills and input backs up
            hold_done     <= 1'b1;
            hold_left     <= HOLD_OFF_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet_phase || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // record checker
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : check_records
        t_sensor_record want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_records.size() == 0) begin
                $error("record with none expected: record_kind %0d value_hundredths %0d",
                       m_axis_tuser, $signed(m_axis_tdata[VALUE_W-1:0]));
                error_count++;
            end else begin
                want = expected_records.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $error("record_kind mismatch: expected %0d, actual %0d",
                           want.kind, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[VALUE_W-1:0] !== want.value) begin
                    $error("value_hundredths mismatch: expected %0d, actual %0d",
                           $signed(want.value), $signed(m_axis_tdata[VALUE_W-1:0]));
                    error_count++;
                end
                if (m_axis_tdata[39:VALUE_W] !== '0) begin
                    $error("tdata pad mismatch: expected 0, actual %0h",
                           m_axis_tdata[39:VALUE_W]);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog on cycles with no beat anywhere
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pwrite && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial begin : run_sequence
        int i;
        for (i = 0; i < STORE_CELLS; i++)
            shadow_cells[i] = 8'h00;
        shadow_collecting = 1'b0;
        shadow_index      = '0;
        shadow_last_co2   = CO2_LAST_RST;
        shadow_limit      = CO2_LIMIT_RST;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bytes outside any frame, a stray star among them
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CH_STAR);
        push_byte(8'h41);

        // each kind but co2 and unknown, digit extremes on pressure, gas resistance and temp2
        build_frame(KIND_TEMP1, FILL_ASCII, 16);
        send_frame();
        build_frame(KIND_PRESSURE, FILL_ZERO_BYTES, 16);
        send_frame();
        build_frame(KIND_HUMIDITY1, FILL_ASCII, 16);
        send_frame();
        build_frame(KIND_GAS_RES, FILL_ONE_BYTES, 16);
        send_frame();
        build_frame(KIND_HUMIDITY2, FILL_ASCII, 16);
        send_frame();
        build_frame(KIND_TEMP2, FILL_ONE_BYTES, 16);
        send_frame();
        build_frame(KIND_GAS1, FILL_ASCII, 16);
        send_frame();

        // co2 kept, rejected right at the limit, kept just inside, kept after wrap, rejected far
        build_frame(KIND_CO2, FILL_ASCII, 16);
        set_reading(1000);
        send_frame();
        build_frame(KIND_CO2, FILL_ASCII, 16);
        set_reading(4000);
        send_frame();
        build_frame(KIND_CO2, FILL_ASCII, 16);
        set_reading(3999);
        send_frame();
        build_frame(KIND_CO2, FILL_ASCII, 16);
        set_reading(69635);
        send_frame();
        build_frame(KIND_CO2, FILL_ASCII, 16);
        set_reading(999999);
        send_frame();

        // unknown tag
        build_frame(KIND_UNKNOWN, FILL_ASCII, 16);
        draft_frame[1] = 8'h78;
        draft_frame[2] = 8'h78;
        send_frame();

        // dollar inside a frame, once on a tag-free cell and once on a digit cell
        build_frame(KIND_TEMP1, FILL_ASCII, 18);
        draft_frame[3] = CH_DOLLAR;
        draft_frame[9] = CH_DOLLAR;
        send_frame();

        // store full, then a short frame that leaves older bytes in place
        build_frame(KIND_PRESSURE, FILL_ANY, 46);
        send_frame();
        build_frame(KIND_HUMIDITY1, FILL_ASCII, 3);
        send_frame();

        // second dollar right after the first, then an unfinished frame run into a new one
        push_byte(CH_DOLLAR);
        build_frame(KIND_TEMP2, FILL_ASCII, 16);
        send_frame();
        push_byte(CH_DOLLAR);
        repeat (5) push_byte(body_byte());
        build_frame(KIND_GAS_RES, FILL_ASCII, 16);
        send_frame();

        // limit of zero rejects every co2 reading
        wait_idle();
        write_jump_limit('0);
        queue_random(90);

        wait_idle();
        write_jump_limit('1);
        queue_random(90);

        wait_idle();
        write_jump_limit(16'd1);
        queue_random(70);

        // long receiver hold-off lands in this phase
        wait_idle();
        write_jump_limit(LIMIT_W'($urandom));
        hold_at_byte <= bytes_queued + 60;
        queue_random(110);

        // back to the reset limit, no idling on either side
        wait_idle();
        write_jump_limit(CO2_LIMIT_RST);
        quiet_phase <= 1'b1;
        queue_random(110);

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
hdl/sfp_pkg.sv
hdl/sfp_cfg.sv
hdl/sfp_collect.sv
hdl/sfp_decode.sv
hdl/sensor_frame_parser.sv
hdl/sfp_checker.sv
sim/tb_sensor_frame_parser.sv
